// ===== rtl/multichannel_moving_average_macros.svh =====
// Assertion macros for the multichannel moving average block.
// Used by the top level only; no other dependencies.
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mma_pkg.sv =====
// Shared types and fixed field widths for the multichannel moving average.
// No dependencies.
`default_nettype none

package mma_pkg;

    localparam int SAMPLE_W  = 10;   // sample field width
    localparam int CHANNEL_W = 2;    // channel field width
    localparam int WIN_W     = 9;    // window_length register width
    localparam int AVG_W     = 10;   // average field width
    localparam int TDATA_W   = 16;   // stream data width, byte padded

    localparam logic [WIN_W-1:0] WINDOW_RESET = 9'd20;

    // Handshake between the sequencer and the divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/mma_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mma_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mma_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on mma_pkg (divisor width, status struct).
`default_nettype none

module mma_divider #(
    parameter int DIVIDEND_W = 19
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [DIVIDEND_W-1:0]       dividend,
    input  wire logic [mma_pkg::WIN_W-1:0]   divisor,
    output mma_pkg::div_status_t             status,
    output logic      [DIVIDEND_W-1:0]       quotient
);

    localparam int WIN_W = mma_pkg::WIN_W;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] acc_reg;     // dividend shifts out, quotient shifts in
    logic [WIN_W-1:0]      rem_reg;
    logic [WIN_W-1:0]      divisor_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [WIN_W:0]        trial;
    logic                  ge;
    logic [WIN_W:0]        diff;

    always_comb begin
        trial = {rem_reg, acc_reg[DIVIDEND_W-1]};
        ge    = trial >= {1'b0, divisor_reg};
        diff  = trial - {1'b0, divisor_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                acc_reg     <= dividend;
                rem_reg     <= '0;
                divisor_reg <= divisor;
                cnt_reg     <= '0;
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                // remainder stays below the divisor, so it fits WIN_W bits
                rem_reg <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
                acc_reg <= {acc_reg[DIVIDEND_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/multichannel_moving_average.sv =====
// Multichannel moving average, top level.
// Depends on mma_pkg, mma_ram, mma_divider and multichannel_moving_average_macros.svh.
//
// Usage:
//   Input stream (s_*): one item per sample, channel number in s_tuser, sample in
//   s_tdata. Result stream (m_*): one item per input item, the truncated mean of
//   the sample and the channel's window_length-1 most recent earlier samples.
//   cfg_wr_en/cfg_wr_data write window_length (0 acts as 1, values above
//   MAX_WINDOW act as MAX_WINDOW); write only while the block is idle.
// Timing:
//   One item at a time. Each item makes n = min(window_length-1, samples seen on
//   that channel so far) history reads through the single history RAM read port,
//   then SUM_BITS steps of the one-bit-per-cycle divider (SUM_BITS = 19 at
//   default parameters). s_tready is high only while the sequencer is idle.
// Reset:
//   Window length returns to 20, per-channel write pointers and fill counts to
//   zero. History RAM is not swept: entries beyond a channel's fill count are never
//   read, so the block is ready in the cycle after reset.
// Stall:
//   The result sits in an output register; the next item is accepted and
//   processed while it waits, and the following result waits for m_tready.
`default_nettype none

`include "multichannel_moving_average_macros.svh"

module multichannel_moving_average #(
    parameter int CHANNELS    = 4,
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mma_pkg::TDATA_W-1:0]     s_tdata,   // [9:0] sample
    input  wire logic [mma_pkg::CHANNEL_W-1:0]   s_tuser,   // [1:0] channel
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [mma_pkg::TDATA_W-1:0]     m_tdata,   // [9:0] average
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [mma_pkg::WIN_W-1:0]       cfg_wr_data
);

    localparam int WIN_W      = mma_pkg::WIN_W;
    localparam int TDATA_W    = mma_pkg::TDATA_W;
    localparam int SW         = (SAMPLE_BITS < mma_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                  : mma_pkg::SAMPLE_W;
    localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
    localparam int ADDR_W     = CH_BITS + SLOT_BITS;
    localparam int DEPTH      = 2 ** ADDR_W;
    localparam int SUM_BITS   = SW + $clog2(MAX_WINDOW + 1);
    localparam int CNT_W      = (WIN_W > SLOT_BITS) ? WIN_W : SLOT_BITS;
    localparam int SAMPLE_MAX = (1 << SW) - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [WIN_W-1:0]     window_reg;
    logic [SLOT_BITS-1:0] newest_reg [CHANNELS];
    logic [SLOT_BITS-1:0] fill_reg   [CHANNELS];

    logic [CH_BITS-1:0]   ch_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [CNT_W-1:0]     nread_reg;
    logic [CNT_W-1:0]     issued_reg;
    logic                 rvalid_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    logic [WIN_W-1:0]     w_reg;
    logic                 m_tvalid_reg;
    logic [TDATA_W-1:0]   m_tdata_reg;

    logic [CH_BITS-1:0]   ch_in;
    logic [SW-1:0]        smp_in;
    logic [WIN_W-1:0]     w_eff;
    logic [SLOT_BITS-1:0] pos_old;
    logic [SLOT_BITS-1:0] pos_new;
    logic [CNT_W-1:0]     nread_next;
    logic                 accept;
    logic                 rd_en;
    logic                 div_start;
    logic [SW-1:0]        rdata;
    logic [SUM_BITS-1:0]  div_quot;
    mma_pkg::div_status_t div_status;

    // channel number reduced modulo CHANNELS; the field is only two bits wide
    always_comb begin
        logic [3:0] ch_work;
        ch_work = 4'(s_tuser);
        for (int i = 0; i < 3; i++) begin
            if (ch_work >= 4'(CHANNELS)) begin
                ch_work = ch_work - 4'(CHANNELS);
            end
        end
        ch_in = ch_work[CH_BITS-1:0];
    end

    always_comb begin
        logic [CNT_W-1:0] span;
        logic [CNT_W-1:0] have;
        w_eff = window_reg;
        if (window_reg == '0) begin
            w_eff = WIN_W'(1);
        end else if (32'(window_reg) > MAX_WINDOW) begin
            w_eff = WIN_W'(MAX_WINDOW);
        end
        span       = CNT_W'(w_eff - 1'b1);
        have       = CNT_W'(fill_reg[ch_in]);
        nread_next = (span < have) ? span : have;
    end

    assign smp_in   = s_tdata[SW-1:0];
    assign pos_old  = newest_reg[ch_in];
    assign pos_new  = (pos_old == SLOT_BITS'(MAX_WINDOW - 1)) ? '0 : pos_old + 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = (state_reg == ST_READ) && (issued_reg != nread_reg);
    assign div_start = (state_reg == ST_READ) && !rd_en && !rvalid_reg;

    // New sample goes to the slot after the newest; the reads of this item
    // never reach that slot, so the write can happen at accept.
    mma_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_history (
        .aclk  (aclk),
        .we    (accept),
        .waddr ({ch_in, pos_new}),
        .wdata (smp_in),
        .re    (rd_en),
        .raddr ({ch_reg, slot_reg}),
        .rdata (rdata)
    );

    mma_divider #(
        .DIVIDEND_W (SUM_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (w_reg),
        .status   (div_status),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            window_reg   <= mma_pkg::WINDOW_RESET;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            issued_reg   <= '0;
            nread_reg    <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                newest_reg[c] <= '0;
                fill_reg[c]   <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            // ST_OUT handles the output register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            rvalid_reg <= rd_en;
            if (rvalid_reg) begin
                sum_reg <= sum_reg + SUM_BITS'(rdata);
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        ch_reg            <= ch_in;
                        slot_reg          <= pos_old;
                        nread_reg         <= nread_next;
                        issued_reg        <= '0;
                        sum_reg           <= SUM_BITS'(smp_in);
                        w_reg             <= w_eff;
                        newest_reg[ch_in] <= pos_new;
                        if (fill_reg[ch_in] != SLOT_BITS'(MAX_WINDOW - 1)) begin
                            fill_reg[ch_in] <= fill_reg[ch_in] + 1'b1;
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (rd_en) begin
                        issued_reg <= issued_reg + 1'b1;
                        slot_reg   <= (slot_reg == '0) ? SLOT_BITS'(MAX_WINDOW - 1)
                                                       : slot_reg - 1'b1;
                    end
                    if (div_start) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // wait for the output register to free up
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= TDATA_W'(div_quot[SW-1:0]);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `MMA_ASSERT_IMP(a_reads_bounded, aclk, aresetn, state_reg == ST_READ, issued_reg <= nread_reg, "history reads overran the window")
    `MMA_ASSERT_IMP(a_div_start_free, aclk, aresetn, div_start, !div_status.busy, "divider started while busy")
    `MMA_ASSERT_NXT(a_div_runs, aclk, aresetn, div_start, div_status.busy && state_reg == ST_DIV, "divider did not take the sum")
    `MMA_ASSERT_IMP(a_avg_range, aclk, aresetn, m_tvalid_reg, m_tdata_reg <= TDATA_W'(SAMPLE_MAX), "average exceeds sample range")

endmodule

`default_nettype wire

// ===== test/multichannel_moving_average_tb.sv =====
// Self-checking testbench for multichannel_moving_average: per-channel mean over a window.
// Predicts every average from its own copy of the channel histories and window setting.
// Depends on mma_pkg and the multichannel_moving_average RTL.
module multichannel_moving_average_tb;
    import mma_pkg::*;

    localparam int N_CH      = 4;
    localparam int HIST_LEN  = 256;
    localparam int CLK_HALF  = 4;
    localparam int LIMIT_CYC = 4_000_000;

    // Tracks channel histories and the window; holds the averages still owed by the block.
    class mean_tracker;
        logic [SAMPLE_W-1:0] history [N_CH][HIST_LEN];
        bit [7:0]            newest  [N_CH];
        bit [WIN_W-1:0]      window;
        logic [AVG_W-1:0]    expected_avgs [$];
        int                  errors;

        function new();
            foreach (history[c, s]) history[c][s] = '0;
            foreach (newest[c]) newest[c] = '0;
            window = WINDOW_RESET;
            errors = 0;
        endfunction

        function void set_window(bit [WIN_W-1:0] value);
            window = value;
        endfunction

        function void note_sample(bit [CHANNEL_W-1:0] ch, bit [SAMPLE_W-1:0] smp);
            int unsigned w;
            int unsigned sum;
            bit [7:0]    pos;
            bit [7:0]    slot;
            // zero acts as one, oversize saturates to the history depth
            w = (window == 0) ? 1 : ((window > HIST_LEN) ? HIST_LEN : window);
            pos = newest[ch];
            sum = smp;
            for (int k = 0; k + 1 < w; k++) begin
                slot = pos - 8'(k);
                sum += history[ch][slot];
            end
            pos = pos + 8'd1;
            history[ch][pos] = smp;
            newest[ch] = pos;
            expected_avgs.push_back(AVG_W'(sum / w));
        endfunction

        function void check_average(logic [TDATA_W-1:0] data);
            logic [AVG_W-1:0] want;
            logic [AVG_W-1:0] got;
            got = data[AVG_W-1:0];
            if (expected_avgs.size() == 0) begin
                $error("average: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = expected_avgs.pop_front();
            if (got !== want) begin
                $error("average: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_avgs.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;    // [9:0] sample
    logic [CHANNEL_W-1:0] s_tuser;    // [1:0] channel
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;    // [9:0] average
    logic                 cfg_wr_en;
    logic [WIN_W-1:0]     cfg_wr_data;

    mean_tracker sb = new();

    multichannel_moving_average i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        #(2 * CLK_HALF * LIMIT_CYC);
        $display("FAIL");
        $finish;
    end

    // Both handshakes are sampled on pre-edge values.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tuser, s_tdata[SAMPLE_W-1:0]);
            if (m_tvalid && m_tready)
                sb.check_average(m_tdata);
        end
    end

    // Receiver back-pressure: spans of always-ready, coin-flip, mostly-stalled and stalled.
    initial begin
        int mode;
        int span;
        m_tready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 60);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= 1'b0;
                endcase
            end
        end
    end

    // Called right after a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input bit [CHANNEL_W-1:0] ch, input bit [SAMPLE_W-1:0] smp);
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= TDATA_W'(smp);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window(input bit [WIN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_window(value);
        @(posedge aclk);
    endtask

    // Bursty random items; channels come in runs, samples lean toward extremes and repeats.
    task automatic send_random_items(input int count);
        int               burst_left;
        int               run_left;
        bit [CHANNEL_W-1:0] ch;
        bit [SAMPLE_W-1:0]  smp;
        int               pick;
        burst_left = $urandom_range(1, 24);
        run_left   = 0;
        ch         = '0;
        smp        = '0;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                ch       = CHANNEL_W'($urandom_range(0, N_CH - 1));
                run_left = $urandom_range(1, 30);
            end
            run_left--;
            pick = $urandom_range(0, 15);
            case (pick)
                0: smp = '0;
                1: smp = '1;
                2: smp = smp;
                default: smp = SAMPLE_W'($urandom_range(0, 1023));
            endcase
            send_item(ch, smp);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 40));
            end
        end
    endtask

    initial begin
        bit [WIN_W-1:0] win_plan [8];
        bit [WIN_W-1:0] win;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        win_plan = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd2, 9'd257, 9'd3, 9'd64};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window: extremes and alternating bit patterns on every channel
        send_item(2'd0, 10'd1023);
        send_item(2'd0, 10'd1023);
        send_item(2'd0, 10'd0);
        send_item(2'd1, 10'd0);
        send_item(2'd1, 10'd1023);
        send_item(2'd2, 10'h2AA);
        send_item(2'd2, 10'h155);
        send_item(2'd3, 10'd1023);
        send_item(2'd3, 10'd1023);
        send_item(2'd3, 10'd1023);
        send_item(2'd3, 10'd1);
        send_item(2'd0, 10'd1);
        wait_drained();
        // zero window acts as one
        write_window(9'd0);
        send_item(2'd2, 10'd1023);
        send_item(2'd2, 10'd5);
        wait_drained();
        // oversize window saturates, stored history carries over
        write_window(9'd511);
        send_item(2'd1, 10'd7);
        send_item(2'd3, 10'd1000);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            win = (p < 8) ? win_plan[p] : WIN_W'($urandom_range(0, 511));
            write_window(win);
            send_random_items(90);
            wait_drained();
        end

        repeat (300) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("average: %0d expected items never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
